// ===== sv/adts_pkg.sv =====
// shared types and constants of the adts frame deframer
package adts_pkg;

   // sync bytes and header sizes
   localparam logic [7:0]  SyncByte    = 8'hFF;
   localparam logic [3:0]  SyncNibble  = 4'hF;
   localparam int          HdrBytes    = 6;
   localparam int          RescanLen   = 5;
   localparam logic [12:0] HdrLenNoCrc = 13'd7;
   localparam logic [12:0] HdrLenCrc   = 13'd9;

   // queue between front and back
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // parse mode of the front
   typedef enum logic [2:0] {
      MODE_HUNT    = 3'b001,
      MODE_HEADER  = 3'b010,
      MODE_PAYLOAD = 3'b100
   } mode_type;

   // decoded header fields of one frame
   typedef struct packed {
      logic [1:0]  profile;
      logic [3:0]  sample_rate_index;
      logic [2:0]  channel_config;
      logic        crc_absent;
      logic        original_copy;
      logic        home_bit;
      logic [12:0] frame_length;
   } hdr_fields_type;

   // one queue entry: a whole header or one payload byte
   typedef struct packed {
      logic                         is_header;
      logic                         last;
      logic [HdrBytes-1:0][7:0]     bytes;
      hdr_fields_type               fields;
   } q_entry_type;

   // header field decode from bytes one to five
   function automatic hdr_fields_type decode_fields(input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3,
                                                    input logic [7:0] b4,
                                                    input logic [7:0] b5);
      hdr_fields_type f;
      f.profile           = b2[7:6];
      f.sample_rate_index = b2[5:2];
      f.channel_config    = {b2[0], b3[7:6]};
      f.crc_absent        = b1[0];
      f.original_copy     = b3[5];
      f.home_bit          = b3[4];
      f.frame_length      = {b3[1:0], b4, b5[7:5]};
      return f;
   endfunction

endpackage

// ===== sv/adts_queue.sv =====
// short entry queue between the front parser and the back emitter
module adts_queue
   import adts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output q_entry_type head_entry,
   output logic        empty
);

   q_entry_type             mem_ff [QDepth];
   logic [QPtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   // status
   assign full       = (count_ff == QCntW'(QDepth));
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("queue count beyond depth");

endmodule

// ===== sv/adts_front.sv =====
// sync hunter, header collector and frame classifier
module adts_front
   import adts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   output logic        in_ready,
   output logic        q_push,
   output q_entry_type q_entry,
   input  logic        q_full
);

   mode_type        mode_ff, mode_in;
   logic [7:0]      hdr_ff [HdrBytes];
   logic [7:0]      hdr_in [HdrBytes];
   logic [2:0]      count_ff, count_in;
   logic [12:0]     bytes_left_ff, bytes_left_in;
   hdr_fields_type  fields_ff, fields_in;
   logic [7:0]      rescan_ff [RescanLen];
   logic [7:0]      rescan_in [RescanLen];
   logic [2:0]      rescan_left_ff, rescan_left_in;
   logic            rescan_active;
   logic            step;
   logic [7:0]      b;
   hdr_fields_type  dec;
   logic [12:0]     hdr_len;

   // byte source: rescan buffer first, then the input
   assign rescan_active = (rescan_left_ff != '0);
   assign in_ready      = !rescan_active && !q_full;
   assign step          = rescan_active || (in_valid && in_ready);
   assign b             = rescan_active ? rescan_ff[0] : in_byte;

   // header decode on the sixth byte
   assign dec     = decode_fields(hdr_ff[1], hdr_ff[2], hdr_ff[3], hdr_ff[4], b);
   assign hdr_len = dec.crc_absent ? HdrLenNoCrc : HdrLenCrc;

   // one parse step
   always_comb begin
      mode_in        = mode_ff;
      hdr_in         = hdr_ff;
      count_in       = count_ff;
      bytes_left_in  = bytes_left_ff;
      fields_in      = fields_ff;
      rescan_in      = rescan_ff;
      rescan_left_in = rescan_left_ff;
      q_push         = 1'b0;
      q_entry        = '0;
      q_entry.fields = fields_ff;

      // rescan buffer shifts one byte per step
      if (rescan_active) begin
         for (int i = 0; i < RescanLen - 1; i++) begin
            rescan_in[i] = rescan_ff[i+1];
         end
         rescan_left_in = rescan_left_ff - 1'b1;
      end

      if (step) begin
         case (mode_ff)
            MODE_PAYLOAD: begin
               bytes_left_in    = bytes_left_ff - 1'b1;
               q_push           = 1'b1;
               q_entry.bytes[0] = b;
               q_entry.last     = (bytes_left_in == '0);
               if (bytes_left_in == '0) begin
                  mode_in  = MODE_HUNT;
                  count_in = '0;
               end
            end
            MODE_HUNT: begin
               if (count_ff == '0) begin
                  if (b == SyncByte) begin
                     hdr_in[0] = b;
                     count_in  = 3'd1;
                  end
               end else if (b[7:4] == SyncNibble) begin
                  hdr_in[1] = b;
                  count_in  = 3'd2;
                  mode_in   = MODE_HEADER;
               end else begin
                  count_in = '0;
               end
            end
            MODE_HEADER: begin
               if (count_ff == 3'(HdrBytes - 1)) begin
                  count_in = '0;
                  if (dec.frame_length < hdr_len) begin
                     // rejected: rescan from the byte after the sync byte
                     mode_in        = MODE_HUNT;
                     rescan_in[0]   = hdr_ff[1];
                     rescan_in[1]   = hdr_ff[2];
                     rescan_in[2]   = hdr_ff[3];
                     rescan_in[3]   = hdr_ff[4];
                     rescan_in[4]   = b;
                     rescan_left_in = 3'(RescanLen);
                  end else begin
                     mode_in           = MODE_PAYLOAD;
                     fields_in         = dec;
                     bytes_left_in     = dec.frame_length - 13'(HdrBytes);
                     q_push            = 1'b1;
                     q_entry.is_header = 1'b1;
                     q_entry.fields    = dec;
                     for (int i = 0; i < HdrBytes - 1; i++) begin
                        q_entry.bytes[i] = hdr_ff[i];
                     end
                     q_entry.bytes[HdrBytes-1] = b;
                  end
               end else begin
                  hdr_in[count_ff] = b;
                  count_in         = count_ff + 1'b1;
               end
            end
            default: begin
               mode_in  = MODE_HUNT;
               count_in = '0;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HUNT;
         count_ff       <= '0;
         rescan_left_ff <= '0;
      end else begin
         mode_ff        <= mode_in;
         count_ff       <= count_in;
         rescan_left_ff <= rescan_left_in;
      end
   end

   // header bytes, counters and latched fields
   always_ff @(posedge clock) begin
      hdr_ff        <= hdr_in;
      rescan_ff     <= rescan_in;
      bytes_left_ff <= bytes_left_in;
      fields_ff     <= fields_in;
   end

   // checks
   a_no_rescan_in_payload: assert property (@(posedge clock) disable iff (reset)
      rescan_active |-> (mode_ff != MODE_PAYLOAD))
      else $error("rescan while in payload");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(HdrBytes - 1))
      else $error("header count out of range");

endmodule

// ===== sv/adts_back.sv =====
// back emitter: expands queue entries into output beats
module adts_back
   import adts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  q_entry_type    head_entry,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           out_valid,
   output logic [7:0]     out_byte,
   output logic           out_start,
   output logic           out_last,
   output hdr_fields_type out_fields,
   input  logic           out_take
);

   logic           valid_ff, valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           start_ff, start_in;
   logic           last_ff, last_in;
   hdr_fields_type fields_ff, fields_in;
   logic [2:0]     idx_ff, idx_in;
   logic           load;

   // output register loads when empty or being taken
   assign load = (!valid_ff || out_take) && !q_empty;

   always_comb begin
      valid_in  = valid_ff && !out_take;
      byte_in   = byte_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      fields_in = fields_ff;
      idx_in    = idx_ff;
      q_pop     = 1'b0;
      if (load) begin
         valid_in  = 1'b1;
         fields_in = head_entry.fields;
         if (head_entry.is_header) begin
            byte_in  = head_entry.bytes[idx_ff];
            start_in = (idx_ff == '0);
            last_in  = 1'b0;
            if (idx_ff == 3'(HdrBytes - 1)) begin
               idx_in = '0;
               q_pop  = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            byte_in  = head_entry.bytes[0];
            start_in = 1'b0;
            last_in  = head_entry.last;
            q_pop    = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // output beat payload
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      start_ff  <= start_in;
      last_ff   <= last_in;
      fields_ff <= fields_in;
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_start  = start_ff;
   assign out_last   = last_ff;
   assign out_fields = fields_ff;

   // checks
   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(start_ff && last_ff))
      else $error("beat marked both start and last");

   a_header_in_progress: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> (!q_empty && head_entry.is_header))
      else $error("header expansion lost its entry");

endmodule

// ===== sv/adts_frame_deframer.sv =====
// top level of the adts frame deframer
//
//   channel  direction  handshake          beat
//   req      in         req_push/req_full  one stream byte
//   rsp      out        rsp_pop/rsp_empty  one frame byte with marks and header fields
//
// one input byte per cycle while no rescan runs and the four-entry queue has room
// a header is one queue entry and leaves as six beats, one per cycle while rsp_pop takes them
// a rejected header holds req_full high while its bytes are rescanned
// the output register frees the front, so a byte is taken while a result waits
// reset is synchronous and returns the parser to sync hunt with an empty queue
module adts_frame_deframer
   import adts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_start,
   output logic        rsp_frame_last,
   output logic [1:0]  rsp_profile,
   output logic [3:0]  rsp_sample_rate_index,
   output logic [2:0]  rsp_channel_config,
   output logic        rsp_crc_absent,
   output logic        rsp_original_copy,
   output logic        rsp_home_bit,
   output logic [12:0] rsp_frame_length
);

   logic           in_ready;
   logic           q_push, q_full, q_pop, q_empty;
   q_entry_type    q_entry, head_entry;
   logic           out_valid;
   hdr_fields_type out_fields;

   assign req_full  = !in_ready;
   assign rsp_empty = !out_valid;

   // front: hunt, collect, classify
   adts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push),
      .in_byte  (req_data_byte),
      .in_ready (in_ready),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_full   (q_full)
   );

   // decoupling queue
   adts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   // back: emit beats
   adts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .out_valid  (out_valid),
      .out_byte   (rsp_out_byte),
      .out_start  (rsp_frame_start),
      .out_last   (rsp_frame_last),
      .out_fields (out_fields),
      .out_take   (rsp_pop)
   );

   assign rsp_profile           = out_fields.profile;
   assign rsp_sample_rate_index = out_fields.sample_rate_index;
   assign rsp_channel_config    = out_fields.channel_config;
   assign rsp_crc_absent        = out_fields.crc_absent;
   assign rsp_original_copy     = out_fields.original_copy;
   assign rsp_home_bit          = out_fields.home_bit;
   assign rsp_frame_length      = out_fields.frame_length;

endmodule

// ===== bench/testbench.sv =====
// testbench of the adts frame deframer: byte stream in, checked frame beats out
`timescale 1ns / 1ps

module testbench;
   import adts_pkg::*;

   // one expected frame beat
   typedef struct packed {
      logic [7:0]     data_val;
      logic           is_first;
      logic           is_last;
      hdr_fields_type hdr;
   } frame_beat_type;

   typedef logic [7:0] byte_seq_type[$];

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 32;
   localparam int MaxPrinted  = 100;

   // block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_start;
   logic        rsp_frame_last;
   logic [1:0]  rsp_profile;
   logic [3:0]  rsp_sample_rate_index;
   logic [2:0]  rsp_channel_config;
   logic        rsp_crc_absent;
   logic        rsp_original_copy;
   logic        rsp_home_bit;
   logic [12:0] rsp_frame_length;

   // bench state
   frame_beat_type expected_beats[$];
   int fail_count    = 0;
   int bytes_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // parser mirror
   mode_type       scan_mode  = MODE_HUNT;
   logic [7:0]     hdr_buf[HdrBytes];
   logic [2:0]     hdr_fill   = 3'd0;
   logic [12:0]    body_left  = 13'd0;
   hdr_fields_type cur_fields = '0;

   adts_frame_deframer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_data_byte         (req_data_byte),
      .req_full              (req_full),
      .rsp_pop               (rsp_pop),
      .rsp_empty             (rsp_empty),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_frame_start       (rsp_frame_start),
      .rsp_frame_last        (rsp_frame_last),
      .rsp_profile           (rsp_profile),
      .rsp_sample_rate_index (rsp_sample_rate_index),
      .rsp_channel_config    (rsp_channel_config),
      .rsp_crc_absent        (rsp_crc_absent),
      .rsp_original_copy     (rsp_original_copy),
      .rsp_home_bit          (rsp_home_bit),
      .rsp_frame_length      (rsp_frame_length)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < MaxPrinted)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [12:0] got,
                              input logic [12:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic void push_beat(input logic [7:0] b, input logic first,
                                     input logic last);
      frame_beat_type beat;
      beat.data_val = b;
      beat.is_first = first;
      beat.is_last  = last;
      beat.hdr      = cur_fields;
      expected_beats.push_back(beat);
   endfunction

   // sync hunt and header collection, true once six header bytes are held
   function automatic bit feed_hunter(input logic [7:0] b);
      if (scan_mode == MODE_HUNT) begin
         if (hdr_fill == 3'd0) begin
            if (b == SyncByte) begin
               hdr_buf[0] = b;
               hdr_fill   = 3'd1;
            end
         end else if (b[7:4] == SyncNibble) begin
            hdr_buf[1] = b;
            hdr_fill   = 3'd2;
            scan_mode  = MODE_HEADER;
         end else begin
            hdr_fill = 3'd0;
         end
         return 1'b0;
      end
      hdr_buf[hdr_fill] = b;
      hdr_fill++;
      return hdr_fill >= 3'(HdrBytes);
   endfunction

   // expected beats caused by one accepted stream byte
   function automatic void predict_byte(input logic [7:0] b);
      hdr_fields_type f;
      logic [12:0]    hdr_len;
      logic [7:0]     rescan[RescanLen];
      if (scan_mode == MODE_PAYLOAD) begin
         body_left = body_left - 13'd1;
         push_beat(b, 1'b0, body_left == 13'd0);
         if (body_left == 13'd0) begin
            scan_mode = MODE_HUNT;
            hdr_fill  = 3'd0;
         end
         return;
      end
      if (!feed_hunter(b))
         return;
      f.crc_absent        = hdr_buf[1][0];
      f.profile           = hdr_buf[2][7:6];
      f.sample_rate_index = hdr_buf[2][5:2];
      f.channel_config    = {hdr_buf[2][0], hdr_buf[3][7:6]};
      f.original_copy     = hdr_buf[3][5];
      f.home_bit          = hdr_buf[3][4];
      f.frame_length      = {hdr_buf[3][1:0], hdr_buf[4], hdr_buf[5][7:5]};
      hdr_len = f.crc_absent ? HdrLenNoCrc : HdrLenCrc;
      // too short: drop it and rescan the bytes after its sync byte
      if (f.frame_length < hdr_len) begin
         for (int k = 0; k < RescanLen; k++)
            rescan[k] = hdr_buf[k + 1];
         scan_mode = MODE_HUNT;
         hdr_fill  = 3'd0;
         for (int k = 0; k < RescanLen; k++)
            void'(feed_hunter(rescan[k]));
         return;
      end
      // accepted: the whole header leaves as a burst
      cur_fields = f;
      for (int k = 0; k < HdrBytes; k++)
         push_beat(hdr_buf[k], k == 0, 1'b0);
      body_left = f.frame_length - 13'd6;
      hdr_fill  = 3'd0;
      scan_mode = MODE_PAYLOAD;
   endfunction

   // one stream byte, called and returning at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_full);
      predict_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_seq(input byte_seq_type seq);
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   task automatic send_payload(input int count);
      logic [31:0] r;
      repeat (count) begin
         r = $urandom;
         send_byte(r[7:0]);
      end
   endtask

   // sync plus five header bytes with random fields
   task automatic send_frame_head(input logic crc_absent, input logic [12:0] flen,
                                  input bit bait);
      logic [31:0] r;
      logic [7:0]  h1, h2, h3, h4, h5;
      r  = $urandom;
      h1 = {SyncNibble, r[2:0], crc_absent};
      h2 = r[10:3];
      h3 = {r[16:11], flen[12:11]};
      h4 = flen[10:3];
      h5 = {flen[2:0], r[21:17]};
      // bait: a second sync inside the header, found again on rescan
      if (bait) begin
         h2      = SyncByte;
         h3[7:4] = SyncNibble;
         h5[1:0] = 2'b00;
      end
      send_byte(SyncByte);
      send_byte(h1);
      send_byte(h2);
      send_byte(h3);
      send_byte(h4);
      send_byte(h5);
   endtask

   // sync byte followed by a byte that does not complete it
   task automatic test_broken_sync();
      byte_seq_type seq;
      seq = {8'h12, SyncByte, 8'h3C};
      send_seq(seq);
   endtask

   // second byte of the sync is itself 0xFF, shortest frame without crc, other fields zero
   task automatic test_sync_then_ff();
      byte_seq_type seq;
      seq = {SyncByte, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h00};
      send_seq(seq);
   endtask

   // all header fields at their maximum, crc header, shortest crc frame
   task automatic test_extreme_fields();
      byte_seq_type seq;
      seq = {SyncByte, 8'hF0, 8'hFF, 8'hFC, 8'h01, 8'h3F, 8'hFF, 8'hFF, 8'hFF};
      send_seq(seq);
   endtask

   // length six is rejected, rescan finds a sync inside the dropped header
   task automatic test_short_header_rescan();
      byte_seq_type seq;
      seq = {SyncByte, 8'hF1, 8'hFF, 8'hF0, 8'h00, 8'hC0,
             8'h01, 8'h20, 8'hAA, 8'h55, 8'hFF};
      send_seq(seq);
   endtask

   // mostly good frames, some short headers and runs of noise
   task automatic test_random_stream(input int count);
      int          stop_at;
      int          kind;
      int          hdr_len;
      int          len;
      logic        crc_absent;
      bit          bait;
      logic [31:0] r;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         kind       = $urandom_range(99);
         crc_absent = 1'($urandom_range(1));
         hdr_len    = crc_absent ? 7 : 9;
         if (kind < 70) begin
            if ($urandom_range(19) == 0)
               len = $urandom_range(120, hdr_len);
            else
               len = $urandom_range(32, hdr_len);
            send_frame_head(crc_absent, 13'(len), 1'b0);
            send_payload(len - HdrBytes);
         end else if (kind < 85) begin
            len  = $urandom_range(hdr_len - 1, 0);
            bait = ($urandom_range(2) == 0);
            send_frame_head(crc_absent, 13'(len), bait);
            // finish the header found on rescan with a small length
            if (bait) begin
               r = $urandom;
               send_byte({5'b00000, r[2:0]});
               send_byte(r[15:8]);
            end
         end else begin
            repeat ($urandom_range(8, 1)) begin
               r = $urandom;
               send_byte(r[9:8] == 2'b00 ? SyncByte : r[7:0]);
            end
         end
      end
   endtask

   // stream ends in the middle of a frame of the longest length
   task automatic test_truncated_tail();
      send_frame_head(1'b1, 13'd8191, 1'b0);
      send_payload(10);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each popped beat with the oldest expected one
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected");
         end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", 13'(rsp_out_byte), 13'(want.data_val));
            check_field("frame_start", 13'(rsp_frame_start), 13'(want.is_first));
            check_field("frame_last", 13'(rsp_frame_last), 13'(want.is_last));
            check_field("profile", 13'(rsp_profile), 13'(want.hdr.profile));
            check_field("sample_rate_index", 13'(rsp_sample_rate_index),
                        13'(want.hdr.sample_rate_index));
            check_field("channel_config", 13'(rsp_channel_config),
                        13'(want.hdr.channel_config));
            check_field("crc_absent", 13'(rsp_crc_absent), 13'(want.hdr.crc_absent));
            check_field("original_copy", 13'(rsp_original_copy),
                        13'(want.hdr.original_copy));
            check_field("home_bit", 13'(rsp_home_bit), 13'(want.hdr.home_bit));
            check_field("frame_length", rsp_frame_length, want.hdr.frame_length);
         end
      end
   end

   // test sequence
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 53;
      test_broken_sync();
      test_sync_then_ff();
      test_extreme_fields();
      test_short_header_rescan();
      test_random_stream(130);

      send_idle_pct = 53;
      recv_idle_pct = 37;
      test_random_stream(130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stream(140);
      test_truncated_tail();

      // drain the remaining beats, then watch for strays
      req_push <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
